@@ rtl/core/emr_pkg.sv @@
// ============================================================================
// emr_pkg
// shared types, constants and helpers of the euler angle round trip block
// ============================================================================
package emr_pkg;

    // field widths and fixed point formats
    localparam int ANG_W         = 16;
    localparam int MAT_W         = 16;
    localparam int AFRAC         = ANG_W - 3;
    localparam int MFRAC         = MAT_W - 2;

    // pipeline shape
    localparam int CORDIC_STAGES = 16;
    localparam int CIDX_W        = 4;
    localparam int SQRT_STAGES   = 31;
    localparam int SIDX_W        = 5;

    // internal word widths (q30 work format)
    localparam int QW = 34;
    localparam int ZW = 35;
    localparam int PW = 2 * QW;
    localparam int RW = 62;

    typedef logic signed [QW-1:0] q30_t;
    typedef logic signed [ZW-1:0] zacc_t;
    typedef q30_t mat_t [3][3];
    typedef logic [8:0][MAT_W-1:0] qpack_t;

    // one cordic lane: vector and angle accumulator
    typedef struct packed {
        logic signed [QW-1:0] x;
        logic signed [QW-1:0] y;
        logic signed [ZW-1:0] z;
    } lane_t;

    // one square root lane: remainder and partial root
    typedef struct packed {
        logic [RW-1:0] rem;
        logic [RW-1:0] root;
    } sqrt_t;

    // decomposition control
    typedef struct packed {
        logic lock;
        logic mid_pos;
        logic neg_b;
    } dec_ctl_t;

    typedef enum logic [2:0] {
        ORD_XYZ = 3'd0,
        ORD_XZY = 3'd1,
        ORD_YXZ = 3'd2,
        ORD_YZX = 3'd3,
        ORD_ZXY = 3'd4,
        ORD_ZYX = 3'd5
    } order_t;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    localparam logic REG_COMPOSE   = 1'b0;
    localparam logic REG_DECOMPOSE = 1'b1;

    localparam q30_t  ONE_Q30     = QW'(64'sd1 <<< 30);
    localparam zacc_t PI_Q30      = ZW'(64'sd3373259426);
    localparam zacc_t HALF_PI_Q30 = ZW'(64'sd1686629713);
    localparam q30_t  GAIN_Q30    =
        QW'(64'sd652032874 + (64'sd434688582 >>> (2 * CORDIC_STAGES)));
    localparam logic signed [MAT_W-1:0] ONE_Q14 = MAT_W'(1 << MFRAC);

    localparam logic [31:0] ATAN_TAB [CORDIC_STAGES] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
        32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
        32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF
    };

    // elementary rotation about one axis
    function automatic mat_t elem_mat(input logic [1:0] axis, input q30_t c, input q30_t s);
        mat_t m;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                m[i][j] = (i == j) ? ONE_Q30 : '0;
            end
        end
        unique case (axis)
            AX_Y: begin
                m[0][0] = c;  m[0][2] = s;
                m[2][0] = -s; m[2][2] = c;
            end
            AX_Z: begin
                m[0][0] = c;  m[0][1] = -s;
                m[1][0] = s;  m[1][1] = c;
            end
            default: begin
                m[1][1] = c;  m[1][2] = -s;
                m[2][1] = s;  m[2][2] = c;
            end
        endcase
        return m;
    endfunction

    // signed matrix entry from the packed q14 matrix
    function automatic logic signed [MAT_W-1:0] qget(input qpack_t q, input int r, input int c);
        return $signed(q[r*3+c]);
    endfunction

endpackage

@@ rtl/core/emr_rot_cell.sv @@
// ============================================================================
// emr_rot_cell
// one rotation-mode cordic step with its output register
// ============================================================================
module emr_rot_cell import emr_pkg::*; (
    input  logic              aclk,
    input  logic              en,
    input  logic [CIDX_W-1:0] idx,
    input  lane_t             lane_in,
    output lane_t             lane_out
);

    lane_t lane_reg, lane_next;
    logic signed [QW-1:0] xs, ys;
    zacc_t ang;

    always_comb begin
        xs  = $signed(lane_in.x) >>> idx;
        ys  = $signed(lane_in.y) >>> idx;
        ang = $signed({3'b000, ATAN_TAB[idx]});
        if (!lane_in.z[ZW-1]) begin
            lane_next.x = lane_in.x - ys;
            lane_next.y = lane_in.y + xs;
            lane_next.z = lane_in.z - ang;
        end else begin
            lane_next.x = lane_in.x + ys;
            lane_next.y = lane_in.y - xs;
            lane_next.z = lane_in.z + ang;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

@@ rtl/core/emr_vec_cell.sv @@
// ============================================================================
// emr_vec_cell
// one vectoring-mode cordic step with its output register
// ============================================================================
module emr_vec_cell import emr_pkg::*; (
    input  logic              aclk,
    input  logic              en,
    input  logic [CIDX_W-1:0] idx,
    input  lane_t             lane_in,
    output lane_t             lane_out
);

    lane_t lane_reg, lane_next;
    logic signed [QW-1:0] xs, ys;
    zacc_t ang;

    always_comb begin
        xs  = $signed(lane_in.x) >>> idx;
        ys  = $signed(lane_in.y) >>> idx;
        ang = $signed({3'b000, ATAN_TAB[idx]});
        if (!lane_in.y[QW-1]) begin
            lane_next.x = lane_in.x + ys;
            lane_next.y = lane_in.y - xs;
            lane_next.z = lane_in.z + ang;
        end else begin
            lane_next.x = lane_in.x - ys;
            lane_next.y = lane_in.y + xs;
            lane_next.z = lane_in.z - ang;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

@@ rtl/core/emr_sqrt_cell.sv @@
// ============================================================================
// emr_sqrt_cell
// one digit of a restoring integer square root
// ============================================================================
module emr_sqrt_cell import emr_pkg::*; (
    input  logic              aclk,
    input  logic              en,
    input  logic [SIDX_W-1:0] idx,
    input  sqrt_t             sq_in,
    output sqrt_t             sq_out
);

    sqrt_t sq_reg, sq_next;
    logic [5:0]    sh;
    logic [RW-1:0] bitv, trial;

    always_comb begin
        sh    = 6'(2 * (SQRT_STAGES - 1)) - {idx, 1'b0};
        bitv  = RW'(1) << sh;
        trial = sq_in.root + bitv;
        if (sq_in.rem >= trial) begin
            sq_next.rem  = sq_in.rem - trial;
            sq_next.root = (sq_in.root >> 1) + bitv;
        end else begin
            sq_next.rem  = sq_in.rem;
            sq_next.root = sq_in.root >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg <= sq_next;
        end
    end

    assign sq_out = sq_reg;

endmodule

@@ rtl/core/emr_mat_mul.sv @@
// ============================================================================
// emr_mat_mul
// two-stage 3x3 q30 matrix product, rounded back to q30
// ============================================================================
module emr_mat_mul import emr_pkg::*; (
    input  logic aclk,
    input  logic en,
    input  mat_t a_in,
    input  mat_t b_in,
    output mat_t r_out
);

    logic signed [PW-1:0]   prod_reg [3][3][3];
    logic signed [PW+1:0]   acc;
    mat_t r_reg, r_next;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    for (int k = 0; k < 3; k++) begin
                        prod_reg[i][j][k] <= PW'(a_in[i][k]) * PW'(b_in[k][j]);
                    end
                end
            end
        end
    end

    // sum of three products, round half up at bit 30
    always_comb begin
        acc = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                acc = (PW+2)'(prod_reg[i][j][0]) + (PW+2)'(prod_reg[i][j][1])
                    + (PW+2)'(prod_reg[i][j][2]) + (PW+2)'(64'sd1 <<< 29);
                r_next[i][j] = QW'(acc >>> 30);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg <= r_next;
        end
    end

    assign r_out = r_reg;

endmodule

@@ rtl/core/euler_angle_matrix_round_trip_top.sv @@
// ============================================================================
// euler_angle_matrix_round_trip_top
// euler angles to rotation matrix and back, fully pipelined
// ============================================================================
// Takes one beat of three Q3.13 angles, builds the rotation matrix in the
// compose order, returns it as Q1.14 and recovers three angles from it in
// the decompose order. The datapath is one long chain of cells: 16 rotation
// cordic cells per angle, two 3x3 product stages, 31 square root digit
// cells, and 16 vectoring cordic cells for each of the three atan2 lanes.
// One beat is accepted every cycle while the output is not stalled. The whole
// chain advances together, so it only halts while the output register holds
// a beat that the sink does not take.
// Order registers must only be written while no beat is in flight.
module euler_angle_matrix_round_trip_top import emr_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    // s_tdata: x_angle_in, y_angle_in, z_angle_in (16 bits each, low first)
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,
    // m_tdata: mat_r0c0 .. mat_r2c2 row-major, then x/y/z_angle_out,
    // 16 bits each, low first
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata,
    // register port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    // side data that rides next to the square root cells
    typedef struct packed {
        qpack_t                    q;
        dec_ctl_t                  ctl;
        logic signed [MAT_W-1:0]   a;
        logic signed [MAT_W-1:0]   by;
        logic signed [MAT_W-1:0]   bx;
        logic signed [MAT_W-1:0]   cy;
        logic signed [MAT_W-1:0]   cx;
    } side_t;

    // side data that rides next to the atan2 cells
    typedef struct packed {
        qpack_t   q;
        dec_ctl_t ctl;
        logic [2:0] zero;
    } tail_t;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [2:0] compose_order_reg, decompose_order_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            compose_order_reg   <= '0;
            decompose_order_reg <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_COMPOSE:   compose_order_reg   <= pwdata[2:0];
                REG_DECOMPOSE: decompose_order_reg <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_DECOMPOSE: prdata = {29'b0, decompose_order_reg};
            default:       prdata = {29'b0, compose_order_reg};
        endcase
    end

    // ------------------------------------------------------------------
    // global advance: the chain moves unless the output beat is stuck
    // ------------------------------------------------------------------
    logic en;
    logic out_valid_reg;
    logic [191:0] out_data_reg, out_data_next;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // ------------------------------------------------------------------
    // input stage: scale to q30 and fold into +-pi/2
    // ------------------------------------------------------------------
    lane_t      rin_reg [3];
    lane_t      rin_next [3];
    logic [2:0] flip0_reg, flip0_next;
    logic       in_v_reg;
    zacc_t      th_raw;

    always_comb begin
        th_raw = '0;
        for (int k = 0; k < 3; k++) begin
            th_raw = ZW'($signed(s_tdata[16*k +: 16])) <<< (30 - AFRAC);
            rin_next[k].x = GAIN_Q30;
            rin_next[k].y = '0;
            flip0_next[k] = 1'b0;
            rin_next[k].z = th_raw;
            if (th_raw > HALF_PI_Q30) begin
                rin_next[k].z = th_raw - PI_Q30;
                flip0_next[k] = 1'b1;
            end else if (th_raw < -HALF_PI_Q30) begin
                rin_next[k].z = th_raw + PI_Q30;
                flip0_next[k] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                rin_reg[k] <= rin_next[k];
            end
            flip0_reg <= flip0_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (en) begin
            in_v_reg <= s_tvalid;
        end
    end

    // ------------------------------------------------------------------
    // sin/cos cells, one lane per axis
    // ------------------------------------------------------------------
    lane_t      rot_lane [3][CORDIC_STAGES+1];
    logic [2:0] flip_line_reg [CORDIC_STAGES];
    logic       rot_v_reg [CORDIC_STAGES];

    for (genvar k = 0; k < 3; k++) begin : g_rot_lane
        assign rot_lane[k][0] = rin_reg[k];
        for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot_cell
            emr_rot_cell u_cell (
                .aclk     (aclk),
                .en       (en),
                .idx      (CIDX_W'(i)),
                .lane_in  (rot_lane[k][i]),
                .lane_out (rot_lane[k][i+1])
            );
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            flip_line_reg[0] <= flip0_reg;
            for (int i = 1; i < CORDIC_STAGES; i++) begin
                flip_line_reg[i] <= flip_line_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CORDIC_STAGES; i++) begin
                rot_v_reg[i] <= 1'b0;
            end
        end else if (en) begin
            rot_v_reg[0] <= in_v_reg;
            for (int i = 1; i < CORDIC_STAGES; i++) begin
                rot_v_reg[i] <= rot_v_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // elementary rotations and operand selection by compose order
    // ------------------------------------------------------------------
    q30_t cos_v [3];
    q30_t sin_v [3];
    mat_t rot_x, rot_y, rot_z;
    mat_t mat_a, mat_b, mat_c;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            cos_v[k] = flip_line_reg[CORDIC_STAGES-1][k] ?
                       -rot_lane[k][CORDIC_STAGES].x : rot_lane[k][CORDIC_STAGES].x;
            sin_v[k] = flip_line_reg[CORDIC_STAGES-1][k] ?
                       -rot_lane[k][CORDIC_STAGES].y : rot_lane[k][CORDIC_STAGES].y;
        end
        rot_x = elem_mat(AX_X, cos_v[0], sin_v[0]);
        rot_y = elem_mat(AX_Y, cos_v[1], sin_v[1]);
        rot_z = elem_mat(AX_Z, cos_v[2], sin_v[2]);
        unique case (order_t'(compose_order_reg))
            ORD_XZY: begin mat_a = rot_x; mat_b = rot_z; mat_c = rot_y; end
            ORD_YXZ: begin mat_a = rot_y; mat_b = rot_x; mat_c = rot_z; end
            ORD_YZX: begin mat_a = rot_y; mat_b = rot_z; mat_c = rot_x; end
            ORD_ZXY: begin mat_a = rot_z; mat_b = rot_x; mat_c = rot_y; end
            ORD_ZYX: begin mat_a = rot_z; mat_b = rot_y; mat_c = rot_x; end
            default: begin mat_a = rot_x; mat_b = rot_y; mat_c = rot_z; end
        endcase
    end

    // ------------------------------------------------------------------
    // two matrix products, (a * b) * c
    // ------------------------------------------------------------------
    mat_t mat_ab, mat_m;
    mat_t mc_reg [2];
    logic mm_v_reg [4];

    emr_mat_mul u_mul_ab (
        .aclk  (aclk),
        .en    (en),
        .a_in  (mat_a),
        .b_in  (mat_b),
        .r_out (mat_ab)
    );

    emr_mat_mul u_mul_c (
        .aclk  (aclk),
        .en    (en),
        .a_in  (mat_ab),
        .b_in  (mc_reg[1]),
        .r_out (mat_m)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            mc_reg[0] <= mat_c;
            mc_reg[1] <= mc_reg[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                mm_v_reg[i] <= 1'b0;
            end
        end else if (en) begin
            mm_v_reg[0] <= rot_v_reg[CORDIC_STAGES-1];
            for (int i = 1; i < 4; i++) begin
                mm_v_reg[i] <= mm_v_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // quantize to q14 and saturate to [-1, +1]
    // ------------------------------------------------------------------
    qpack_t q_reg, q_next;
    logic   q_v_reg;
    q30_t   qr;

    always_comb begin
        qr = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                qr = (mat_m[i][j] + QW'(64'sd1 <<< (29 - MFRAC))) >>> (30 - MFRAC);
                if (qr > QW'(ONE_Q14)) begin
                    q_next[i*3+j] = ONE_Q14;
                end else if (qr < -QW'(ONE_Q14)) begin
                    q_next[i*3+j] = -ONE_Q14;
                end else begin
                    q_next[i*3+j] = MAT_W'(qr);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= q_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_v_reg <= 1'b0;
        end else if (en) begin
            q_v_reg <= mm_v_reg[3];
        end
    end

    // ------------------------------------------------------------------
    // decomposition setup: pivot, lock detect, atan2 operands
    // ------------------------------------------------------------------
    logic signed [MAT_W-1:0] p_v, a_v, bny, bnx, cy_v, cx_v, lpy, lny, lx;
    logic                    neg_on_lock, lock_pos, lock_neg;
    logic signed [2*MAT_W-1:0] a_sq;
    logic [28:0]             rad_hi;
    side_t                   d_side_next, d_side_reg;
    sqrt_t                   d_sq_next, d_sq_reg;
    logic                    d_v_reg;

    always_comb begin
        p_v = qget(q_reg, 0, 2); a_v = p_v;
        bny = -qget(q_reg, 1, 2); bnx = qget(q_reg, 2, 2);
        cy_v = -qget(q_reg, 0, 1); cx_v = qget(q_reg, 0, 0);
        lpy = qget(q_reg, 1, 0); lny = lpy; lx = qget(q_reg, 1, 1);
        neg_on_lock = 1'b1;
        unique case (order_t'(decompose_order_reg))
            ORD_XZY: begin
                p_v = qget(q_reg, 0, 1); a_v = -p_v;
                bny = qget(q_reg, 2, 1); bnx = qget(q_reg, 1, 1);
                cy_v = qget(q_reg, 0, 2); cx_v = qget(q_reg, 0, 0);
                lpy = -qget(q_reg, 2, 0); lny = qget(q_reg, 2, 0);
                lx = qget(q_reg, 2, 2);
                neg_on_lock = 1'b0;
            end
            ORD_YXZ: begin
                p_v = qget(q_reg, 1, 2); a_v = -p_v;
                bny = qget(q_reg, 0, 2); bnx = qget(q_reg, 2, 2);
                cy_v = qget(q_reg, 1, 0); cx_v = qget(q_reg, 1, 1);
                lpy = -qget(q_reg, 0, 1); lny = lpy; lx = qget(q_reg, 0, 0);
            end
            ORD_YZX: begin
                p_v = qget(q_reg, 1, 0); a_v = p_v;
                bny = -qget(q_reg, 2, 0); bnx = qget(q_reg, 0, 0);
                cy_v = -qget(q_reg, 1, 2); cx_v = qget(q_reg, 1, 1);
                lpy = qget(q_reg, 2, 1); lny = lpy; lx = qget(q_reg, 2, 2);
            end
            ORD_ZXY: begin
                p_v = qget(q_reg, 2, 1); a_v = p_v;
                bny = -qget(q_reg, 0, 1); bnx = qget(q_reg, 1, 1);
                cy_v = -qget(q_reg, 2, 0); cx_v = qget(q_reg, 2, 2);
                lpy = qget(q_reg, 0, 2); lny = lpy; lx = qget(q_reg, 0, 0);
            end
            ORD_ZYX: begin
                p_v = qget(q_reg, 2, 0); a_v = -p_v;
                bny = qget(q_reg, 1, 0); bnx = qget(q_reg, 0, 0);
                cy_v = qget(q_reg, 2, 1); cx_v = qget(q_reg, 2, 2);
                lpy = -qget(q_reg, 1, 2); lny = lpy; lx = qget(q_reg, 1, 1);
            end
            default: ;
        endcase

        lock_pos = (p_v >= ONE_Q14);
        lock_neg = (p_v <= -ONE_Q14);

        d_side_next.q           = q_reg;
        d_side_next.ctl.lock    = lock_pos || lock_neg;
        d_side_next.ctl.mid_pos = !a_v[MAT_W-1];
        d_side_next.ctl.neg_b   = lock_neg && neg_on_lock;
        d_side_next.a           = a_v;
        d_side_next.cy          = cy_v;
        d_side_next.cx          = cx_v;
        if (lock_pos) begin
            d_side_next.by = lpy;
            d_side_next.bx = lx;
        end else if (lock_neg) begin
            d_side_next.by = lny;
            d_side_next.bx = lx;
        end else begin
            d_side_next.by = bny;
            d_side_next.bx = bnx;
        end

        // cos of the middle angle: sqrt(2^60 - v^2), v = a << 16
        a_sq           = a_v * a_v;
        rad_hi         = 29'(1 << 28) - 29'(a_sq);
        d_sq_next.rem  = RW'({rad_hi, 32'b0});
        d_sq_next.root = '0;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_side_reg <= d_side_next;
            d_sq_reg   <= d_sq_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_v_reg <= 1'b0;
        end else if (en) begin
            d_v_reg <= q_v_reg;
        end
    end

    // ------------------------------------------------------------------
    // square root cells, side data in step
    // ------------------------------------------------------------------
    sqrt_t sq_lane [SQRT_STAGES+1];
    side_t sq_side_reg [SQRT_STAGES];
    logic  sq_v_reg [SQRT_STAGES];

    assign sq_lane[0] = d_sq_reg;

    for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_sqrt_cell
        emr_sqrt_cell u_cell (
            .aclk   (aclk),
            .en     (en),
            .idx    (SIDX_W'(i)),
            .sq_in  (sq_lane[i]),
            .sq_out (sq_lane[i+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_side_reg[0] <= d_side_reg;
            for (int i = 1; i < SQRT_STAGES; i++) begin
                sq_side_reg[i] <= sq_side_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SQRT_STAGES; i++) begin
                sq_v_reg[i] <= 1'b0;
            end
        end else if (en) begin
            sq_v_reg[0] <= d_v_reg;
            for (int i = 1; i < SQRT_STAGES; i++) begin
                sq_v_reg[i] <= sq_v_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // atan2 prologue: zero detect, left half plane folded by +-pi
    // ------------------------------------------------------------------
    side_t sq_last;
    q30_t  pre_x [3];
    q30_t  pre_y [3];
    lane_t v0_next [3];
    lane_t v0_reg [3];
    tail_t v0_tail_next, v0_tail_reg;
    logic  v0_v_reg;

    assign sq_last = sq_side_reg[SQRT_STAGES-1];

    always_comb begin
        pre_y[0] = QW'(sq_last.a)  <<< (30 - MFRAC);
        pre_x[0] = QW'(sq_lane[SQRT_STAGES].root);
        pre_y[1] = QW'(sq_last.by) <<< (30 - MFRAC);
        pre_x[1] = QW'(sq_last.bx) <<< (30 - MFRAC);
        pre_y[2] = QW'(sq_last.cy) <<< (30 - MFRAC);
        pre_x[2] = QW'(sq_last.cx) <<< (30 - MFRAC);
        v0_tail_next.q   = sq_last.q;
        v0_tail_next.ctl = sq_last.ctl;
        for (int k = 0; k < 3; k++) begin
            v0_tail_next.zero[k] = (pre_x[k] == '0) && (pre_y[k] == '0);
            if (pre_x[k][QW-1]) begin
                v0_next[k].x = -pre_x[k];
                v0_next[k].y = -pre_y[k];
                v0_next[k].z = pre_y[k][QW-1] ? -PI_Q30 : PI_Q30;
            end else begin
                v0_next[k].x = pre_x[k];
                v0_next[k].y = pre_y[k];
                v0_next[k].z = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                v0_reg[k] <= v0_next[k];
            end
            v0_tail_reg <= v0_tail_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_v_reg <= 1'b0;
        end else if (en) begin
            v0_v_reg <= sq_v_reg[SQRT_STAGES-1];
        end
    end

    // ------------------------------------------------------------------
    // atan2 cells: lane 0 middle angle, lanes 1 and 2 outer angles
    // ------------------------------------------------------------------
    lane_t vec_lane [3][CORDIC_STAGES+1];
    tail_t vec_tail_reg [CORDIC_STAGES];
    logic  vec_v_reg [CORDIC_STAGES];

    for (genvar k = 0; k < 3; k++) begin : g_vec_lane
        assign vec_lane[k][0] = v0_reg[k];
        for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec_cell
            emr_vec_cell u_cell (
                .aclk     (aclk),
                .en       (en),
                .idx      (CIDX_W'(i)),
                .lane_in  (vec_lane[k][i]),
                .lane_out (vec_lane[k][i+1])
            );
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vec_tail_reg[0] <= v0_tail_reg;
            for (int i = 1; i < CORDIC_STAGES; i++) begin
                vec_tail_reg[i] <= vec_tail_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CORDIC_STAGES; i++) begin
                vec_v_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vec_v_reg[0] <= v0_v_reg;
            for (int i = 1; i < CORDIC_STAGES; i++) begin
                vec_v_reg[i] <= vec_v_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // angle assembly, lock handling, rounding and saturation
    // ------------------------------------------------------------------
    tail_t       fin;
    zacc_t       za [3];
    zacc_t       ang [3];
    zacc_t       rnd;
    logic [1:0]  ax_mid, ax_b, ax_c;
    logic [ANG_W-1:0] ang_out [3];

    assign fin = vec_tail_reg[CORDIC_STAGES-1];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            za[k] = fin.zero[k] ? '0 : vec_lane[k][CORDIC_STAGES].z;
        end
        unique case (order_t'(decompose_order_reg))
            ORD_XZY: begin ax_mid = AX_Z; ax_b = AX_X; ax_c = AX_Y; end
            ORD_YXZ: begin ax_mid = AX_X; ax_b = AX_Y; ax_c = AX_Z; end
            ORD_YZX: begin ax_mid = AX_Z; ax_b = AX_Y; ax_c = AX_X; end
            ORD_ZXY: begin ax_mid = AX_X; ax_b = AX_Z; ax_c = AX_Y; end
            ORD_ZYX: begin ax_mid = AX_Y; ax_b = AX_Z; ax_c = AX_X; end
            default: begin ax_mid = AX_Y; ax_b = AX_X; ax_c = AX_Z; end
        endcase
        for (int k = 0; k < 3; k++) begin
            ang[k] = '0;
        end
        // gimbal lock: middle angle pinned to +-pi/2, third angle zero
        if (fin.ctl.lock) begin
            ang[ax_mid] = fin.ctl.mid_pos ? HALF_PI_Q30 : -HALF_PI_Q30;
            ang[ax_b]   = fin.ctl.neg_b ? -za[1] : za[1];
            ang[ax_c]   = '0;
        end else begin
            ang[ax_mid] = za[0];
            ang[ax_b]   = za[1];
            ang[ax_c]   = za[2];
        end
        rnd = '0;
        for (int k = 0; k < 3; k++) begin
            rnd = (ang[k] + ZW'(64'sd1 <<< (29 - AFRAC))) >>> (30 - AFRAC);
            if (rnd > ZW'(64'sd32767)) begin
                ang_out[k] = ANG_W'(16'h7FFF);
            end else if (rnd < -ZW'(64'sd32768)) begin
                ang_out[k] = ANG_W'(16'h8000);
            end else begin
                ang_out[k] = ANG_W'(rnd);
            end
        end
        out_data_next = {ang_out[2], ang_out[1], ang_out[0], fin.q};
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (en) begin
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= vec_v_reg[CORDIC_STAGES-1];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ rtl/core/emr_checker.sv @@
// ============================================================================
// emr_checker
// port-level checks of the euler angle round trip block
// ============================================================================
module emr_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [191:0] m_tdata
);

    // no beat comes out right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output beat after reset");

    // input side only waits while an output beat is held
    a_ready_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    // held output beat stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    // matrix entries r0c0 and r1c1 stay within +-1.0
    a_mat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[15:0]) <= 16'sd16384)
                  && ($signed(m_tdata[15:0]) >= -16'sd16384)
                  && ($signed(m_tdata[79:64]) <= 16'sd16384)
                  && ($signed(m_tdata[79:64]) >= -16'sd16384))
        else $error("matrix entry beyond unit range");

endmodule

bind euler_angle_matrix_round_trip_top emr_checker u_emr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ dv/euler_angle_matrix_round_trip_checker.sv @@
`timescale 1ns / 100ps
// ============================================================================
// euler_angle_matrix_round_trip_checker
// watches the angle and matrix streams, predicts each result beat and compares
// ============================================================================
module euler_angle_matrix_round_trip_checker import emr_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [47:0]  s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [191:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic         pready,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output int           errors,
    output int           pending
);

    typedef longint m3_t [3][3];

    localparam longint HP   = 64'sd1686629713;
    localparam longint PI   = 64'sd3373259426;
    localparam longint ONE  = 64'sd1 <<< 30;
    localparam longint QONE = 64'sd1 <<< MFRAC;
    localparam int     NST  = 16;

    localparam longint ARCTAN [NST] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
        64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
        64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF
    };

    logic [2:0] compose_sel, decompose_sel;
    logic [191:0] expected_beats [$];

    function automatic longint round_shift(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void sin_cos(input longint th, output longint c, output longint s);
        longint x, y, t;
        bit flip;
        flip = 0;
        if (th > HP) begin
            th -= PI; flip = 1;
        end else if (th < -HP) begin
            th += PI; flip = 1;
        end
        x = 64'sd652032874 + ((2 * NST >= 63) ? 64'sd0 : (64'sd434688582 >>> (2 * NST)));
        y = 0;
        for (int i = 0; i < NST; i++) begin
            if (th >= 0) begin
                t = x - (y >>> i); y = y + (x >>> i); th -= ARCTAN[i];
            end else begin
                t = x + (y >>> i); y = y - (x >>> i); th += ARCTAN[i];
            end
            x = t;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint vec_angle(input longint y, input longint x);
        longint z, t;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? PI : -PI; x = -x; y = -y;
        end
        for (int i = 0; i < NST; i++) begin
            if (y >= 0) begin
                t = x + (y >>> i); y = y - (x >>> i); z += ARCTAN[i];
            end else begin
                t = x - (y >>> i); y = y + (x >>> i); z -= ARCTAN[i];
            end
            x = t;
        end
        return z;
    endfunction

    // atan2 of two q14 matrix entries
    function automatic longint entry_angle(input longint qy, input longint qx);
        return vec_angle(qy <<< (30 - MFRAC), qx <<< (30 - MFRAC));
    endfunction

    function automatic longint int_sqrt(input longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b; res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint entry_asin(input longint qv);
        longint v;
        longint unsigned sq, one2;
        v = qv <<< (30 - MFRAC);
        sq = v * v;
        one2 = 64'd1 << 60;
        return vec_angle(v, int_sqrt(sq < one2 ? one2 - sq : 64'd0));
    endfunction

    function automatic m3_t mul3(input m3_t a, input m3_t b);
        m3_t r;
        longint acc;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                acc = 0;
                for (int k = 0; k < 3; k++) acc += a[i][k] * b[k][j];
                r[i][j] = round_shift(acc, 30);
            end
        end
        return r;
    endfunction

    function automatic m3_t axis_rot(input int ax, input longint c, input longint s);
        m3_t m;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) m[i][j] = (i == j) ? ONE : 0;
        if (ax == 0) begin
            m[1][1] = c; m[1][2] = -s; m[2][1] = s; m[2][2] = c;
        end else if (ax == 1) begin
            m[0][0] = c; m[0][2] = s; m[2][0] = -s; m[2][2] = c;
        end else begin
            m[0][0] = c; m[0][1] = -s; m[1][0] = s; m[1][1] = c;
        end
        return m;
    endfunction

    // full round trip of one angle beat: packed matrix then recovered angles
    function automatic logic [191:0] round_trip(input logic [47:0] angles);
        m3_t rot [3];
        m3_t prod;
        longint q [3][3];
        longint c, s, ax, ay, az, p, amax;
        int o0, o1, o2;
        logic [191:0] beat;
        amax = (64'sd1 <<< (ANG_W - 1)) - 1;
        for (int i = 0; i < 3; i++) begin
            sin_cos(longint'($signed(angles[16*i +: 16])) <<< (30 - AFRAC), c, s);
            rot[i] = axis_rot(i, c, s);
        end
        case (compose_sel)
            ORD_XZY: begin o0 = 0; o1 = 2; o2 = 1; end
            ORD_YXZ: begin o0 = 1; o1 = 0; o2 = 2; end
            ORD_YZX: begin o0 = 1; o1 = 2; o2 = 0; end
            ORD_ZXY: begin o0 = 2; o1 = 0; o2 = 1; end
            ORD_ZYX: begin o0 = 2; o1 = 1; o2 = 0; end
            default: begin o0 = 0; o1 = 1; o2 = 2; end
        endcase
        prod = mul3(mul3(rot[o0], rot[o1]), rot[o2]);
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                q[i][j] = clip(round_shift(prod[i][j], 30 - MFRAC), -QONE, QONE);
                beat[16*(3*i+j) +: 16] = q[i][j][15:0];
            end
        end
        case (decompose_sel)
            ORD_XZY: begin
                p = q[0][1];
                if (p >= QONE) begin
                    az = -HP; ax = entry_angle(-q[2][0], q[2][2]); ay = 0;
                end else if (p <= -QONE) begin
                    az = HP; ax = entry_angle(q[2][0], q[2][2]); ay = 0;
                end else begin
                    az = entry_asin(-p); ax = entry_angle(q[2][1], q[1][1]);
                    ay = entry_angle(q[0][2], q[0][0]);
                end
            end
            ORD_YXZ: begin
                p = q[1][2];
                if (p >= QONE) begin
                    ax = -HP; ay = entry_angle(-q[0][1], q[0][0]); az = 0;
                end else if (p <= -QONE) begin
                    ax = HP; ay = -entry_angle(-q[0][1], q[0][0]); az = 0;
                end else begin
                    ax = entry_asin(-p); ay = entry_angle(q[0][2], q[2][2]);
                    az = entry_angle(q[1][0], q[1][1]);
                end
            end
            ORD_YZX: begin
                p = q[1][0];
                if (p >= QONE) begin
                    az = HP; ay = entry_angle(q[2][1], q[2][2]); ax = 0;
                end else if (p <= -QONE) begin
                    az = -HP; ay = -entry_angle(q[2][1], q[2][2]); ax = 0;
                end else begin
                    az = entry_asin(p); ay = entry_angle(-q[2][0], q[0][0]);
                    ax = entry_angle(-q[1][2], q[1][1]);
                end
            end
            ORD_ZXY: begin
                p = q[2][1];
                if (p >= QONE) begin
                    ax = HP; az = entry_angle(q[0][2], q[0][0]); ay = 0;
                end else if (p <= -QONE) begin
                    ax = -HP; az = -entry_angle(q[0][2], q[0][0]); ay = 0;
                end else begin
                    ax = entry_asin(p); az = entry_angle(-q[0][1], q[1][1]);
                    ay = entry_angle(-q[2][0], q[2][2]);
                end
            end
            ORD_ZYX: begin
                p = q[2][0];
                if (p >= QONE) begin
                    ay = -HP; az = entry_angle(-q[1][2], q[1][1]); ax = 0;
                end else if (p <= -QONE) begin
                    ay = HP; az = -entry_angle(-q[1][2], q[1][1]); ax = 0;
                end else begin
                    ay = entry_asin(-p); az = entry_angle(q[1][0], q[0][0]);
                    ax = entry_angle(q[2][1], q[2][2]);
                end
            end
            default: begin
                // xyz, and the two unused codes
                p = q[0][2];
                if (p >= QONE) begin
                    ay = HP; ax = entry_angle(q[1][0], q[1][1]); az = 0;
                end else if (p <= -QONE) begin
                    ay = -HP; ax = -entry_angle(q[1][0], q[1][1]); az = 0;
                end else begin
                    ay = entry_asin(p); ax = entry_angle(-q[1][2], q[2][2]);
                    az = entry_angle(-q[0][1], q[0][0]);
                end
            end
        endcase
        ax = clip(round_shift(ax, 30 - AFRAC), -amax - 1, amax);
        ay = clip(round_shift(ay, 30 - AFRAC), -amax - 1, amax);
        az = clip(round_shift(az, 30 - AFRAC), -amax - 1, amax);
        beat[159:144] = ax[15:0];
        beat[175:160] = ay[15:0];
        beat[191:176] = az[15:0];
        return beat;
    endfunction

    localparam string FIELD_NAME [12] = '{
        "mat_r0c0", "mat_r0c1", "mat_r0c2", "mat_r1c0", "mat_r1c1", "mat_r1c2",
        "mat_r2c0", "mat_r2c1", "mat_r2c2", "x_angle_out", "y_angle_out", "z_angle_out"
    };

    assign pending = expected_beats.size();

    always @(posedge aclk) begin
        logic [191:0] want;
        if (!aresetn) begin
            compose_sel   <= ORD_XYZ;
            decompose_sel <= ORD_XYZ;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_COMPOSE) compose_sel <= pwdata[2:0];
                else decompose_sel <= pwdata[2:0];
            end
            if (s_tvalid && s_tready) expected_beats.push_back(round_trip(s_tdata));
            if (m_tvalid && m_tready) begin
                if (expected_beats.size() == 0) begin
                    $error("result beat with nothing expected: %h", m_tdata);
                    errors++;
                end else begin
                    want = expected_beats.pop_front();
                    for (int f = 0; f < 12; f++) begin
                        if (m_tdata[16*f +: 16] !== want[16*f +: 16]) begin
                            $error("%s: expected %0d, got %0d", FIELD_NAME[f],
                                   $signed(want[16*f +: 16]), $signed(m_tdata[16*f +: 16]));
                            errors++;
                        end
                    end
                end
            end
        end
    end

    initial errors = 0;

endmodule

@@ dv/euler_angle_matrix_round_trip_top_tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// euler_angle_matrix_round_trip_top_tb
// streams angle triples through the round trip block under all order settings
// ============================================================================
// Directed corner angles first, then random phases, each with its own pair
// of compose and decompose orders. The checker predicts every result beat.
module euler_angle_matrix_round_trip_top_tb;
    import emr_pkg::*;

    localparam int  IDLE_LIMIT = 20000;
    localparam int  LATENCY    = 72;
    localparam int  NEAR_LOCK  = 12868;   // pi/2 in q3.13, just above

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [47:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [191:0] m_tdata;
    logic         psel = 0, penable = 0, pwrite = 0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    int           errors, pending;
    bit           burst_mode = 0;      // no sender gaps in this phase
    bit           hold_req = 0;        // ask the sink for one long stall
    bit           hold_done = 0;
    int           idle_cycles = 0;

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    euler_angle_matrix_round_trip_top u_top (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    euler_angle_matrix_round_trip_checker u_checker (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata,
        .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .errors, .pending
    );

    // watchdog: any beat or register write counts as progress
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result sink: mostly ready, short stalls, rare long ones, one very long hold
    initial begin
        int len;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                m_tready <= 0;
                repeat (300) @(negedge aclk);
                hold_done = 1;
            end else if ($urandom_range(0, 99) < 75) begin
                m_tready <= 1;
            end else begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 50)
                                                    : $urandom_range(1, 3);
                m_tready <= 0;
                repeat (len - 1) @(negedge aclk);
            end
        end
    end

    // register write: setup then access, entered and left at a falling edge
    task automatic reg_write(input logic reg_idx, input logic [2:0] val);
        psel <= 1; pwrite <= 1; penable <= 0;
        paddr <= {reg_idx, 2'b00};
        pwdata <= {29'($urandom()), val};
        @(negedge aclk);
        penable <= 1;
        @(negedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    // one angle beat, with a random gap ahead of it
    task automatic send_angles(input logic [15:0] ax, input logic [15:0] ay,
                               input logic [15:0] az);
        int r, gap;
        r = $urandom_range(0, 99);
        gap = burst_mode ? 0 : (r < 70 ? 0 : (r < 95 ? $urandom_range(1, 3)
                                                     : $urandom_range(10, 40)));
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {az, ay, ax};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // drain: sender stops, waits for all results, lets the pipe settle
    task automatic drain();
        s_tvalid <= 0;
        while (pending != 0) @(negedge aclk);
        repeat (LATENCY + 8) @(negedge aclk);
    endtask

    function automatic logic [15:0] rand_angle();
        int k;
        k = $urandom_range(0, 9);
        if (k < 6) return 16'($urandom());
        if (k < 8) return $urandom_range(0, 1) ? 16'(NEAR_LOCK - $urandom_range(0, 8))
                                                : 16'(-NEAR_LOCK + $urandom_range(0, 8));
        if (k == 8) return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        return 16'($signed($urandom_range(0, 64)) - 32);
    endfunction

    initial begin
        logic [15:0] dir [24][3];
        logic [2:0]  comp_seq [12];
        logic [2:0]  dec_seq [12];
        int sel;
        logic [15:0] a [3];

        comp_seq = '{ORD_ZYX, ORD_XZY, ORD_YZX, ORD_YXZ, ORD_ZXY, 3'd7,
                     ORD_XYZ, ORD_ZYX, ORD_XYZ, ORD_XZY, 3'd6, ORD_YZX};
        dec_seq  = '{ORD_ZYX, ORD_YZX, ORD_XZY, ORD_ZXY, ORD_YXZ, 3'd6,
                     ORD_ZYX, ORD_XYZ, ORD_XZY, 3'd7, ORD_ZXY, ORD_YXZ};

        // corner angles: zero, range ends, both sides of pi/2, lock about y
        dir = '{
            '{16'd0, 16'd0, 16'd0},          '{16'sh7fff, 16'sh7fff, 16'sh7fff},
            '{16'sh8000, 16'sh8000, 16'sh8000}, '{16'sh7fff, 16'sh8000, 16'd0},
            '{16'd12867, 16'd12867, 16'd12867}, '{16'd12868, 16'd12868, 16'd12868},
            '{-16'sd12867, -16'sd12868, -16'sd12867}, '{16'd0, 16'd12868, 16'd0},
            '{16'd0, -16'sd12868, 16'd0},    '{16'd4000, 16'd12868, -16'sd3000},
            '{-16'sd5000, -16'sd12868, 16'd7000}, '{16'd12868, 16'd0, 16'd0},
            '{16'd0, 16'd0, 16'd12868},      '{16'd25736, 16'd0, 16'd0},
            '{16'd0, 16'd25736, -16'sd25736}, '{16'd1, -16'sd1, 16'd1},
            '{16'd8192, 16'd8192, 16'd8192}, '{-16'sd8192, 16'd4096, -16'sd2048},
            '{16'd0, 16'd0, -16'sd12868},    '{16'd12868, 16'd12868, 16'd0},
            '{16'sh5555, 16'shaaaa, 16'sh5555}, '{16'shaaaa, 16'sh5555, 16'shaaaa},
            '{16'd0, 16'd12867, 16'd0},      '{16'd100, 16'sh8000, 16'sh7fff}
        };

        repeat (12) @(posedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // directed part at reset orders
        reg_write(REG_COMPOSE, ORD_XYZ);
        reg_write(REG_DECOMPOSE, ORD_XYZ);
        foreach (dir[i]) send_angles(dir[i][0], dir[i][1], dir[i][2]);
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            reg_write(REG_COMPOSE, comp_seq[ph]);
            reg_write(REG_DECOMPOSE, dec_seq[ph]);
            burst_mode = (ph % 4 == 1);
            // long receiver hold while the sender keeps pushing
            if (ph == 2) hold_req = 1;
            for (int n = 0; n < 102; n++) begin
                sel = $urandom_range(0, 2);
                foreach (a[k]) a[k] = rand_angle();
                // set one randomly chosen axis to +-pi/2 now and then
                if ($urandom_range(0, 3) == 0)
                    a[sel] = $urandom_range(0, 1) ? 16'(NEAR_LOCK) : 16'(-NEAR_LOCK);
                send_angles(a[0], a[1], a[2]);
            end
            drain();
        end

        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ euler_angle_matrix_round_trip_top.f @@
rtl/core/emr_pkg.sv
rtl/core/emr_rot_cell.sv
rtl/core/emr_vec_cell.sv
rtl/core/emr_sqrt_cell.sv
rtl/core/emr_mat_mul.sv
rtl/core/euler_angle_matrix_round_trip_top.sv
rtl/core/emr_checker.sv
dv/euler_angle_matrix_round_trip_checker.sv
dv/euler_angle_matrix_round_trip_top_tb.sv
